>>> src/lmcd_pkg.sv
// ---------------------------------------------------------------------------
// lmcd_pkg
// Shared types and constants of the LED matrix chain driver: command codes,
// register opcodes, controller states and the control and status bundles.
// ---------------------------------------------------------------------------
`default_nettype none

package lmcd_pkg;

  // Chain sizing
  localparam int LMCD_MAX_DEVICES     = 8;
  localparam int ROWS_PER_DEVICE      = 8;
  localparam logic [3:0] DEVICE_COUNT_RESET = 4'd8;

  // Register opcodes of one controller
  localparam logic [3:0] OP_NOOP        = 4'd0;
  localparam logic [3:0] REG_INTENSITY  = 4'd10;
  localparam logic [3:0] REG_SCAN_LIMIT = 4'd11;
  localparam logic [3:0] REG_SHUTDOWN   = 4'd12;

  // Data limits
  localparam logic [7:0] LED_MASK_TOP   = 8'h80;
  localparam logic [7:0] SCANLIMIT_MAX  = 8'd7;
  localparam logic [7:0] INTENSITY_MAX  = 8'd15;
  localparam logic [2:0] LAST_ROW       = 3'd7;

  // Command codes
  typedef enum logic [2:0] {
    ACT_SET_LED    = 3'd0,
    ACT_SET_ROW    = 3'd1,
    ACT_SET_COLUMN = 3'd2,
    ACT_CLEAR      = 3'd3,
    ACT_SHUTDOWN   = 3'd4,
    ACT_SCANLIMIT  = 3'd5,
    ACT_INTENSITY  = 3'd6
  } action_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MODIFY,
    ST_EMIT
  } state_t;

  // Fields of one command item
  typedef struct packed {
    logic [2:0] action;
    logic [2:0] device;
    logic [2:0] position;
    logic [2:0] column_index;
    logic [7:0] value;
    logic       flag;
  } cmd_fields_t;

  // Fields of one result word
  typedef struct packed {
    logic [3:0] reg_addr;
    logic [7:0] reg_data;
    logic       end_of_frame;
    logic       last;
  } word_fields_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;      // latch the incoming command
    logic read;        // read the addressed row byte
    logic modify;      // build the frame word, update the row store
    logic word_next;   // advance to the next chain position
    logic frame_next;  // advance to the next frame of the command
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic drop;        // incoming command is out of range
    logic last_word;   // current word closes its frame
    logic last_frame;  // current frame closes the command
  } dp_stat_t;

endpackage

`default_nettype wire

>>> src/lmcd_if.sv
// ---------------------------------------------------------------------------
// lmcd_cmd_if / lmcd_word_if
// Valid/ready channels of the LED matrix chain driver: command items in,
// serial-link words out.
// ---------------------------------------------------------------------------
`default_nettype none

interface lmcd_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [2:0] device;
  logic [2:0] position;
  logic [2:0] column_index;
  logic [7:0] value;
  logic       flag;

  modport source (
    output valid, action, device, position, column_index, value, flag,
    input  ready
  );
  modport sink (
    input  valid, action, device, position, column_index, value, flag,
    output ready
  );
endinterface

interface lmcd_word_if;
  logic       valid;
  logic       ready;
  logic [3:0] reg_addr;
  logic [7:0] reg_data;
  logic       end_of_frame;
  logic       last;

  modport source (
    output valid, reg_addr, reg_data, end_of_frame, last,
    input  ready
  );
  modport sink (
    input  valid, reg_addr, reg_data, end_of_frame, last,
    output ready
  );
endinterface

`default_nettype wire

>>> src/lmcd_ctrl.sv
// ---------------------------------------------------------------------------
// lmcd_ctrl
// Sequencer of the chain driver: takes one command, then for each frame
// reads the row store, builds the frame and walks the chain positions.
// ---------------------------------------------------------------------------
`default_nettype none

module lmcd_ctrl
  import lmcd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  state_t state, state_next;

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      ST_IDLE: begin
        // Keep the input closed while reset is held
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.accept = 1'b1;
          if (!stat.drop) begin
            state_next = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_MODIFY;
      end
      ST_MODIFY: begin
        cmd.modify = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (!stat.last_word) begin
            cmd.word_next = 1'b1;
          end else if (stat.last_frame) begin
            state_next = ST_IDLE;
          end else begin
            cmd.frame_next = 1'b1;
            state_next     = ST_READ;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // A kept command always starts with a row read
  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !stat.drop) |=> cmd.read)
    else $error("accepted command did not start a frame");

  // A built frame is offered on the next cycle
  a_modify_emits: assert property (@(posedge clk) disable iff (rst)
    cmd.modify |=> out_valid)
    else $error("frame built but no word offered");

  // The closing word of a command frees the input
  a_done_frees_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && stat.last_word && stat.last_frame) |=> in_ready)
    else $error("input not freed after last word");

  // No new command while words are still going out
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input open during word output");

endmodule

`default_nettype wire

>>> src/lmcd_dpath.sv
// ---------------------------------------------------------------------------
// lmcd_dpath
// Datapath of the chain driver: chain size register, command registers,
// row store with per-row valid bits, frame and word counters, word build.
// ---------------------------------------------------------------------------
`default_nettype none

module lmcd_dpath
  import lmcd_pkg::*;
#(
  parameter int MAX_DEVICES = LMCD_MAX_DEVICES
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [3:0]   cfg_wdata,
  input  cmd_fields_t  fields,
  input  dp_cmd_t      cmd,
  output dp_stat_t     stat,
  output word_fields_t word
);

  localparam int MEM_DEPTH = MAX_DEVICES * ROWS_PER_DEVICE;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int NW        = $clog2(MAX_DEVICES + 1);
  localparam int KW        = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int CW        = (NW > 4) ? NW : 4;

  logic [3:0]     device_count;
  logic [CW-1:0]  count_ext;
  logic [CW-1:0]  size_ext;
  logic [NW-1:0]  chain_n;
  logic [NW+2:0]  last_pos_full;
  logic [NW+2:0]  target_full;
  logic           drop;

  action_t        act;
  logic [2:0]     dev;
  logic [2:0]     pos;
  logic [2:0]     col;
  logic [7:0]     val;
  logic           flg;

  logic [2:0]     frame;
  logic [KW-1:0]  k;
  logic [KW-1:0]  last_k;
  logic [KW-1:0]  target_k;
  logic [3:0]     op;
  logic [7:0]     data;

  logic [7:0]     mem [MEM_DEPTH];
  logic           row_valid [MEM_DEPTH];
  logic [7:0]     rd_data;
  logic           rd_valid;

  logic           multi_frame;
  logic [2:0]     row_sel;
  logic [AW+5:0]  addr_full;
  logic [AW-1:0]  addr;
  logic [2:0]     col_sel;
  logic           led_on;
  logic [7:0]     mask;
  logic [7:0]     old_byte;
  logic [7:0]     led_byte;
  logic           wr_en;
  logic [7:0]     wr_byte;
  logic [3:0]     op_next;
  logic [7:0]     data_next;

  // Chain size register
  always_ff @(posedge clk) begin
    if (rst) begin
      device_count <= DEVICE_COUNT_RESET;
    end else if (cfg_we) begin
      device_count <= cfg_wdata;
    end
  end

  // Clamp the chain size to the supported range
  always_comb begin
    count_ext = CW'(device_count);
    if (count_ext == '0 || count_ext > CW'(MAX_DEVICES)) begin
      size_ext = CW'(MAX_DEVICES);
    end else begin
      size_ext = count_ext;
    end
    chain_n       = size_ext[NW-1:0];
    last_pos_full = {3'b000, chain_n} - (NW+3)'(1);
    target_full   = last_pos_full - {{NW{1'b0}}, fields.device};
  end

  // Drop commands that address nothing, carry an unknown action or an out-of-range value
  always_comb begin
    drop = ({{NW{1'b0}}, fields.device} >= {3'b000, chain_n});
    case (action_t'(fields.action))
      ACT_SET_LED, ACT_SET_ROW, ACT_SET_COLUMN, ACT_CLEAR, ACT_SHUTDOWN: ;
      ACT_SCANLIMIT: begin
        if (fields.value > SCANLIMIT_MAX) drop = 1'b1;
      end
      ACT_INTENSITY: begin
        if (fields.value > INTENSITY_MAX) drop = 1'b1;
      end
      default: begin
        drop = 1'b1;
      end
    endcase
  end

  // Latch the command fields
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act      <= action_t'(fields.action);
      dev      <= fields.device;
      pos      <= fields.position;
      col      <= fields.column_index;
      val      <= fields.value;
      flg      <= fields.flag;
      target_k <= target_full[KW-1:0];
    end
  end

  // Frame and chain position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      frame  <= '0;
      k      <= '0;
      last_k <= '0;
    end else begin
      if (cmd.accept) begin
        frame  <= '0;
        k      <= '0;
        last_k <= last_pos_full[KW-1:0];
      end
      if (cmd.modify) begin
        k <= '0;
      end
      if (cmd.word_next) begin
        k <= k + KW'(1);
      end
      if (cmd.frame_next) begin
        frame <= frame + 3'd1;
      end
    end
  end

  // Row and column of the current frame
  always_comb begin
    multi_frame = (act == ACT_SET_COLUMN) || (act == ACT_CLEAR);
    row_sel     = multi_frame ? frame : pos;
    addr_full   = {{AW{1'b0}}, dev, row_sel};
    addr        = addr_full[AW-1:0];
    col_sel     = (act == ACT_SET_COLUMN) ? pos : col;
    led_on      = (act == ACT_SET_COLUMN) ? val[frame] : flg;
    mask        = LED_MASK_TOP >> col_sel;
    old_byte    = rd_valid ? rd_data : 8'h00;
    led_byte    = led_on ? (old_byte | mask) : (old_byte & ~mask);
  end

  // Pick opcode, data and row store update for the frame
  always_comb begin
    wr_en     = 1'b0;
    wr_byte   = 8'h00;
    op_next   = {1'b0, row_sel} + 4'd1;
    data_next = 8'h00;
    case (act)
      ACT_SET_LED, ACT_SET_COLUMN: begin
        wr_en     = 1'b1;
        wr_byte   = led_byte;
        data_next = led_byte;
      end
      ACT_SET_ROW: begin
        wr_en     = 1'b1;
        wr_byte   = val;
        data_next = val;
      end
      ACT_CLEAR: begin
        wr_en = 1'b1;
      end
      ACT_SHUTDOWN: begin
        op_next   = REG_SHUTDOWN;
        data_next = {7'b0000000, ~flg};
      end
      ACT_SCANLIMIT: begin
        op_next   = REG_SCAN_LIMIT;
        data_next = val;
      end
      ACT_INTENSITY: begin
        op_next   = REG_INTENSITY;
        data_next = val;
      end
      default: begin
        op_next = OP_NOOP;
      end
    endcase
  end

  // Row store: read a byte, then write the updated one
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_data <= mem[addr];
    end
    if (cmd.modify && wr_en) begin
      mem[addr] <= wr_byte;
    end
  end

  // Valid bits: an unwritten row reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MEM_DEPTH; i++) begin
        row_valid[i] <= 1'b0;
      end
      rd_valid <= 1'b0;
    end else begin
      if (cmd.read) begin
        rd_valid <= row_valid[addr];
      end
      if (cmd.modify && wr_en) begin
        row_valid[addr] <= 1'b1;
      end
    end
  end

  // Hold the frame word
  always_ff @(posedge clk) begin
    if (cmd.modify) begin
      op   <= op_next;
      data <= data_next;
    end
  end

  // Build the word for the current chain position
  always_comb begin
    stat.drop         = drop;
    stat.last_word    = (k == last_k);
    stat.last_frame   = multi_frame ? (frame == LAST_ROW) : 1'b1;
    word.reg_addr     = (k == target_k) ? op : OP_NOOP;
    word.reg_data     = (k == target_k) ? data : 8'h00;
    word.end_of_frame = stat.last_word;
    word.last         = stat.last_word && stat.last_frame;
  end

  // The position counter never runs past the end of the chain
  a_k_in_chain: assert property (@(posedge clk) disable iff (rst)
    k <= last_k)
    else $error("chain position beyond chain end");

  // Hold the frame while its words go out
  a_frame_holds: assert property (@(posedge clk) disable iff (rst)
    cmd.word_next |=> $stable(frame))
    else $error("frame changed inside a frame");

  // Single-frame commands never advance the frame counter
  a_single_frame: assert property (@(posedge clk) disable iff (rst)
    (cmd.frame_next) |-> multi_frame)
    else $error("frame advance on single-frame command");

endmodule

`default_nettype wire

>>> src/led_matrix_chain_driver.sv
// ---------------------------------------------------------------------------
// led_matrix_chain_driver
// Turns LED matrix commands into frames of 12-bit register words for a
// daisy chain of 8x8 matrix controllers, keeping a shadow of all row bytes.
// ---------------------------------------------------------------------------
// One command is taken at a time. An accepted command is latched from the
// input; then for each frame the shadow row byte is read, the byte is
// updated and the frame built, and one word per chained controller is sent,
// farthest controller first, while the output is ready. Set column and clear
// send eight frames; the other commands send one frame. A dropped command
// is taken on the input and gives no word. The single port of the row
// store, one read and one write per frame, sets the per-frame overhead. The
// row store is usable right after reset: per-row valid bits clear at once,
// so there is no clearing pass.
`default_nettype none

module led_matrix_chain_driver
  import lmcd_pkg::*;
#(
  parameter int MAX_DEVICES = LMCD_MAX_DEVICES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  lmcd_cmd_if.sink    cmd,
  lmcd_word_if.source word
);

  cmd_fields_t  fields;
  word_fields_t word_out;
  dp_cmd_t      dp_cmd;
  dp_stat_t     dp_stat;
  logic         in_ready;
  logic         out_valid;

  // Gather the command fields
  assign fields.action       = cmd.action;
  assign fields.device       = cmd.device;
  assign fields.position     = cmd.position;
  assign fields.column_index = cmd.column_index;
  assign fields.value        = cmd.value;
  assign fields.flag         = cmd.flag;

  lmcd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (word.ready),
    .cmd       (dp_cmd),
    .stat      (dp_stat)
  );

  lmcd_dpath #(
    .MAX_DEVICES (MAX_DEVICES)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fields    (fields),
    .cmd       (dp_cmd),
    .stat      (dp_stat),
    .word      (word_out)
  );

  // Drive the channels
  assign cmd.ready         = in_ready;
  assign word.valid        = out_valid;
  assign word.reg_addr     = word_out.reg_addr;
  assign word.reg_data     = word_out.reg_data;
  assign word.end_of_frame = word_out.end_of_frame;
  assign word.last         = word_out.last;

endmodule

`default_nettype wire
